>>> design/tlb2_pkg.sv
// Shared types and codes for the two-level TLB.
package tlb2_pkg;

  localparam int ModeW    = 2;
  localparam int OffsetW  = 12;
  localparam int VpageW   = 36;
  localparam int PageW    = 32;
  localparam int OutcomeW = 2;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    TGT_INST   = 2'd0,
    TGT_DATA   = 2'd1,
    TGT_SHARED = 2'd2,
    TGT_NONE   = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    OUT_L1_HIT = 2'd0,
    OUT_L2_HIT = 2'd1,
    OUT_MISS   = 2'd2,
    OUT_DONE   = 2'd3
  } outcome_t;

  // Back end: read the L2 line, then apply the item.
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_t;

  // One queued request between front and back.
  typedef struct packed {
    mode_t                mode;
    logic                 is_data;
    logic [VpageW-1:0]    vpage;
    logic [OffsetW-1:0]   offset;
    logic [PageW-1:0]     walked;
    target_t              target;
  } req_t;

  localparam int ReqW = $bits(req_t);

endpackage

>>> design/tlb2_front.sv
// Front end: accepts items and holds them in a small queue for the back end.
module tlb2_front
  import tlb2_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  output logic full,
  output logic req_valid,
  output req_t req,
  input  logic req_take
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  req_t              q_r [Depth];
  logic [PtrW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PtrW:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == (PtrW+1)'(Depth));
  assign req_valid = (cnt_r != '0);
  assign req       = q_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PtrW'(Depth-1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == PtrW'(Depth-1)) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= push_req;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(Depth)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !do_pop) else $error("pop from empty queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("count did not follow push");

endmodule

>>> design/tlb2_back.sv
// Back end: L1 arrays, L2 line RAM, lookup/fill/flush, and the result register.
module tlb2_back
  import tlb2_pkg::*;
#(
  parameter int FirstLines  = 16,
  parameter int SecondLines = 64,
  parameter int VpageBits   = 36,
  parameter int FrameBits   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  input  req_t                 req,
  output logic                 req_take,
  output logic                 res_valid,
  output outcome_t             res_outcome,
  output logic [PageW-1:0]     res_page,
  output logic [OffsetW-1:0]   res_offset,
  input  logic                 res_take
);

  localparam int I1W   = $clog2(FirstLines);
  localparam int I2W   = $clog2(SecondLines);
  localparam int T1W   = VpageBits - I1W;
  localparam int T2W   = VpageBits - I2W;
  localparam int LineW = T2W + FrameBits;

  // L1 arrays in flops; every entry clears on reset or on a flush of its own L1.
  logic             iv_r [FirstLines];
  logic [T1W-1:0]   it_r [FirstLines];
  logic [FrameBits-1:0] if_r [FirstLines];
  logic             dv_r [FirstLines];
  logic [T1W-1:0]   dt_r [FirstLines];
  logic [FrameBits-1:0] df_r [FirstLines];
  // L2 valid bits; tag and frame live in the RAM and are only used behind a valid bit
  logic [SecondLines-1:0] sv_r;

  back_state_t          bk_r, bk_nxt;
  req_t                 cur_r;

  logic                 out_v_r;
  outcome_t             out_o_r;
  logic [PageW-1:0]     out_p_r;
  logic [OffsetW-1:0]   out_off_r;

  logic [I2W-1:0]       rd_addr;
  logic [LineW-1:0]     rd_line;
  logic                 l2_wr;
  logic [T2W-1:0]       l2_tag;
  logic [FrameBits-1:0] l2_frame;

  logic [VpageBits-1:0] vpn, old_vpn;
  logic [I1W-1:0]       i1, oi;
  logic [I2W-1:0]       i2;
  logic [T1W-1:0]       t1, ot;
  logic [T2W-1:0]       t2;
  logic [FrameBits-1:0] walked;
  logic                 own_v, own_hit, l2_hit, oth_match;
  logic [T1W-1:0]       own_t, oth_t;
  logic [FrameBits-1:0] own_f;
  logic                 go;
  outcome_t             o_nxt;
  logic [FrameBits-1:0] p_nxt;

  assign res_valid   = out_v_r;
  assign res_outcome = out_o_r;
  assign res_page    = out_p_r;
  assign res_offset  = out_off_r;

  always_comb begin
    bk_nxt = bk_r;
    unique case (bk_r)
      BK_IDLE: if (req_valid) bk_nxt = BK_EXEC;
      BK_EXEC: if (go) bk_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    req_take = 1'b0;
    go       = 1'b0;
    unique case (bk_r)
      BK_IDLE: req_take = req_valid;
      BK_EXEC: go = !out_v_r || res_take;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) bk_r <= BK_IDLE;
    else        bk_r <= bk_nxt;
  end

  always_ff @(posedge clk) begin
    if (req_take) cur_r <= req;
  end

  assign rd_addr = req.vpage[I2W-1:0];

  tlb2_ram #(.Width(LineW), .Depth(SecondLines)) u_l2_ram (
    .clk, .wr_en(l2_wr), .wr_addr(i2), .wr_data({t2, walked}),
    .rd_en(req_take), .rd_addr, .rd_data(rd_line)
  );

  assign l2_tag   = rd_line[LineW-1:FrameBits];
  assign l2_frame = rd_line[FrameBits-1:0];

  assign vpn     = cur_r.vpage[VpageBits-1:0];
  assign i1      = vpn[I1W-1:0];
  assign t1      = vpn[VpageBits-1:I1W];
  assign i2      = vpn[I2W-1:0];
  assign t2      = vpn[VpageBits-1:I2W];
  assign walked  = cur_r.walked[FrameBits-1:0];
  assign old_vpn = {l2_tag, i2};
  assign oi      = old_vpn[I1W-1:0];
  assign ot      = old_vpn[VpageBits-1:I1W];

  always_comb begin
    own_v = cur_r.is_data ? dv_r[i1] : iv_r[i1];
    own_t = cur_r.is_data ? dt_r[i1] : it_r[i1];
    own_f = cur_r.is_data ? df_r[i1] : if_r[i1];
    oth_t = cur_r.is_data ? it_r[oi] : dt_r[oi];
  end
  assign own_hit   = own_v && (own_t == t1);
  assign l2_hit    = sv_r[i2] && (l2_tag == t2);
  assign oth_match = sv_r[i2] && (oth_t == ot);

  always_comb begin
    o_nxt = OUT_DONE;
    p_nxt = '0;
    unique case (cur_r.mode)
      MODE_LOOKUP: begin
        if (own_hit) begin
          o_nxt = OUT_L1_HIT;
          p_nxt = own_f;
        end else if (l2_hit) begin
          o_nxt = OUT_L2_HIT;
          p_nxt = l2_frame;
        end else begin
          o_nxt = OUT_MISS;
        end
      end
      MODE_FILL: p_nxt = walked;
      MODE_FLUSH, MODE_NONE: ;
      default: ;
    endcase
  end

  logic                 w1, wflush_i, wflush_d, wflush_s;
  logic [FrameBits-1:0] w1f;
  assign w1 = go && ((cur_r.mode == MODE_FILL) ||
              ((cur_r.mode == MODE_LOOKUP) && !own_hit && l2_hit));
  assign w1f = (cur_r.mode == MODE_FILL) ? walked : l2_frame;
  assign l2_wr = go && (cur_r.mode == MODE_FILL);
  assign wflush_i = go && (cur_r.mode == MODE_FLUSH) && (cur_r.target == TGT_INST);
  assign wflush_d = go && (cur_r.mode == MODE_FLUSH) && (cur_r.target == TGT_DATA);
  assign wflush_s = go && (cur_r.mode == MODE_FLUSH) && (cur_r.target == TGT_SHARED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FirstLines; k++) begin
        iv_r[k] <= 1'b0; it_r[k] <= '0; if_r[k] <= '0;
        dv_r[k] <= 1'b0; dt_r[k] <= '0; df_r[k] <= '0;
      end
      sv_r <= '0;
    end else begin
      if (wflush_i) begin
        for (int k = 0; k < FirstLines; k++) begin
          iv_r[k] <= 1'b0; it_r[k] <= '0; if_r[k] <= '0;
        end
      end
      if (wflush_d) begin
        for (int k = 0; k < FirstLines; k++) begin
          dv_r[k] <= 1'b0; dt_r[k] <= '0; df_r[k] <= '0;
        end
      end
      if (wflush_s) sv_r <= '0;
      if (l2_wr) begin
        // displaced L2 line knocks out the other L1's copy first
        if (oth_match) begin
          if (cur_r.is_data) iv_r[oi] <= 1'b0;
          else               dv_r[oi] <= 1'b0;
        end
        sv_r[i2] <= 1'b1;
      end
      if (w1) begin
        if (cur_r.is_data) begin
          dv_r[i1] <= 1'b1; dt_r[i1] <= t1; df_r[i1] <= w1f;
        end else begin
          iv_r[i1] <= 1'b1; it_r[i1] <= t1; if_r[i1] <= w1f;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (go) out_v_r <= 1'b1;
    else if (res_take) out_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_o_r   <= o_nxt;
      out_p_r   <= PageW'(p_nxt);
      out_off_r <= cur_r.offset;
    end
  end

  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !res_take) |-> !go) else $error("result overwritten");
  a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (go && cur_r.mode == MODE_FILL) |=> sv_r[$past(i2)])
    else $error("fill left L2 line invalid");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_o_r == OUT_MISS) |-> (out_p_r == '0))
    else $error("miss with nonzero page");

endmodule

// Generic single-port-write RAM with registered read.
module tlb2_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem_r[rd_addr];
  end

endmodule

>>> design/two_level_tlb_lookup_fill.sv
// Top level of the two-level TLB: queue front end and TLB back end.
//
// Usage: items enter on in_* with push/full; results leave on out_* with
// empty/pop, one result per item, in order. mode 0 looks up virt_page in
// the L1 chosen by access_kind, then in the shared L2 (an L2 hit refills
// the L1); outcome 2 means a walk is needed. mode 1 writes walked_page into
// the L2 line and the accessed L1, dropping the other L1's copy of a
// displaced translation. mode 2 clears the TLB named by flush_target.
// When the block is idle, an item moves from the front queue to an L2 line
// RAM read, then to a step that applies it and registers the result.
// The back end finishes an item before it takes the next, so the L2 read
// never sees a stale line. The front queue holds two items. When the
// receiver stalls (no pop), the result register holds, the back end stops,
// and full rises once the front queue fills. Reset clears all valid bits
// and the L1 tags and frames and empties the front queue and the result
// register; L2 lines are only used behind their valid bit.
module two_level_tlb_lookup_fill
  import tlb2_pkg::*;
#(
  parameter int FIRST_LINES  = 16,
  parameter int SECOND_LINES = 64,
  parameter int VPAGE_BITS   = 36,
  parameter int FRAME_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           in_mode,
  input  logic                 in_access_kind,
  input  logic [VpageW-1:0]    in_virt_page,
  input  logic [OffsetW-1:0]   in_virt_offset,
  input  logic [PageW-1:0]     in_walked_page,
  input  logic [1:0]           in_flush_target,
  output logic                 empty,
  input  logic                 pop,
  output logic [OutcomeW-1:0]  out_outcome,
  output logic [PageW-1:0]     out_phys_page,
  output logic [OffsetW-1:0]   out_phys_offset
);

  req_t     push_req, req;
  logic     req_valid, req_take, res_valid;
  outcome_t res_outcome;

  always_comb begin
    push_req.mode    = mode_t'(in_mode);
    push_req.is_data = in_access_kind;
    push_req.vpage   = in_virt_page;
    push_req.offset  = in_virt_offset;
    push_req.walked  = in_walked_page;
    push_req.target  = target_t'(in_flush_target);
  end

  tlb2_front #(.Depth(2)) u_front (
    .clk, .rst_n, .push, .push_req, .full,
    .req_valid, .req, .req_take
  );

  tlb2_back #(
    .FirstLines(FIRST_LINES), .SecondLines(SECOND_LINES),
    .VpageBits(VPAGE_BITS), .FrameBits(FRAME_BITS)
  ) u_back (
    .clk, .rst_n, .req_valid, .req, .req_take,
    .res_valid, .res_outcome, .res_page(out_phys_page),
    .res_offset(out_phys_offset), .res_take(pop)
  );

  assign empty       = !res_valid;
  assign out_outcome = res_outcome;

endmodule
